### src/rau_pkg.sv
// Shared types and constants for the rational arithmetic unit.
`timescale 1ns / 1ps
`default_nettype none
package rau_pkg;

	localparam int WORD_BITS_DEF = 64;

	localparam logic [2:0] MODE_ADD = 3'd0;
	localparam logic [2:0] MODE_SUB = 3'd1;
	localparam logic [2:0] MODE_MUL = 3'd2;
	localparam logic [2:0] MODE_DIV = 3'd3;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_ZERO_DEN = 2'd1;
	localparam logic [1:0] ST_OVERFLOW = 2'd2;

	typedef struct packed {
		logic [2:0]         mode;
		logic signed [63:0] a_num;
		logic signed [63:0] a_den;
		logic signed [63:0] b_num;
		logic [62:0]        b_den;
	} req_t;

	typedef struct packed {
		logic signed [63:0] res_num;
		logic [62:0]        res_den;
		logic [1:0]         status;
	} rsp_t;

	typedef enum logic [4:0] {
		DP_NOP,
		DP_LOAD,
		DP_NORM,
		DP_MUL_INIT1,
		DP_MUL_INIT2,
		DP_MUL_INIT3,
		DP_MUL_STEP,
		DP_SAVE_P1,
		DP_COMBINE,
		DP_SAVE_RD,
		DP_GCD_INIT,
		DP_GCD_STEP,
		DP_DIV_INIT_N,
		DP_DIV_INIT_D,
		DP_DIV_STEP,
		DP_SAVE_QN,
		DP_SAVE_QD,
		DP_EMIT
	} dp_op_t;

	typedef struct packed {
		logic err;
		logic norm;
		logic addsub;
		logic mul_last;
		logic gcd_done;
		logic div_last;
		logic rn_zero;
	} dp_stat_t;

	typedef enum logic [4:0] {
		S_IDLE,
		S_CHK,
		S_MUL1,
		S_SAVE1,
		S_INIT2,
		S_MUL2,
		S_COMB,
		S_INIT3,
		S_MUL3,
		S_SAVE3,
		S_ZCHK,
		S_GCD,
		S_DINIT_N,
		S_DIV_N,
		S_SAVE_QN,
		S_DINIT_D,
		S_DIV_D,
		S_SAVE_QD,
		S_EMIT,
		S_OUT
	} ctrl_state_t;

	typedef enum logic [1:0] {
		GCD_TWOS,
		GCD_STRIP_A,
		GCD_LOOP,
		GCD_RESTORE
	} gcd_phase_t;

endpackage
`default_nettype wire

### src/rau_dp.sv
// Datapath: operand registers, serial multiplier, binary gcd and restoring divider.
`timescale 1ns / 1ps
`default_nettype none
module rau_dp import rau_pkg::*; #(
	parameter int WORD_BITS = WORD_BITS_DEF
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire dp_op_t   op,
	input  wire req_t     req,
	output dp_stat_t      stat,
	output rsp_t          rsp
);
	localparam logic [127:0] LIM = 128'(1) << (WORD_BITS - 1);

	logic         addsub_q, sub_q, norm_q, div_q, mul_q, err_q;
	logic         sa_q, sb_q, neg_q;
	logic [63:0]  an_q, ad_q, bn_q;
	logic [62:0]  bd_q;
	logic [127:0] rn_q, rd_q;
	logic [63:0]  mx_q, my_q;
	logic [127:0] acc_q;
	logic [5:0]   mcnt_q;
	logic [127:0] ga_q, gb_q;
	logic [6:0]   gk_q;
	gcd_phase_t   gph_q;
	logic [127:0] dn_q;
	logic [128:0] rem_q;
	logic [6:0]   dcnt_q;
	rsp_t         rsp_q;

	logic [63:0]  l_an, l_ad, l_bn;
	logic         l_sa, l_sb;
	logic [128:0] rem_sh;
	logic         q_bit;
	logic         c_s2;

	always_comb begin
		l_an   = req.a_num[63] ? 64'(-req.a_num) : 64'(req.a_num);
		l_ad   = req.a_den[63] ? 64'(-req.a_den) : 64'(req.a_den);
		l_bn   = req.b_num[63] ? 64'(-req.b_num) : 64'(req.b_num);
		l_sa   = req.a_num[63] ^ req.a_den[63];
		l_sb   = req.b_num[63];
		rem_sh = {rem_q[127:0], dn_q[127]};
		q_bit  = rem_sh >= {1'b0, ga_q};
		c_s2   = sb_q ^ sub_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addsub_q      <= 1'b0;
			sub_q         <= 1'b0;
			norm_q        <= 1'b0;
			div_q         <= 1'b0;
			mul_q         <= 1'b0;
			err_q         <= 1'b0;
			sa_q          <= 1'b0;
			sb_q          <= 1'b0;
			neg_q         <= 1'b0;
			an_q          <= '0;
			ad_q          <= '0;
			bn_q          <= '0;
			bd_q          <= '0;
			rn_q          <= '0;
			rd_q          <= '0;
			mx_q          <= '0;
			my_q          <= '0;
			acc_q         <= '0;
			mcnt_q        <= '0;
			ga_q          <= '0;
			gb_q          <= '0;
			gk_q          <= '0;
			gph_q         <= GCD_TWOS;
			dn_q          <= '0;
			rem_q         <= '0;
			dcnt_q        <= '0;
			rsp_q.res_num <= '0;
			rsp_q.res_den <= 63'd1;
			rsp_q.status  <= ST_OK;
		end else begin
			case (op)
				DP_LOAD: begin
					an_q     <= l_an;
					ad_q     <= l_ad;
					bn_q     <= l_bn;
					bd_q     <= req.b_den;
					sa_q     <= l_sa;
					sb_q     <= l_sb;
					addsub_q <= (req.mode == MODE_ADD) || (req.mode == MODE_SUB);
					sub_q    <= req.mode == MODE_SUB;
					mul_q    <= req.mode == MODE_MUL;
					div_q    <= req.mode == MODE_DIV;
					norm_q   <= req.mode > MODE_DIV;
					neg_q    <= (req.mode > MODE_DIV) ? l_sa : (l_sa ^ l_sb);
					err_q    <= (l_ad == 64'd0)
						|| ((req.mode <= MODE_DIV) && (req.b_den == 63'd0))
						|| ((req.mode == MODE_DIV) && (l_bn == 64'd0));
				end
				DP_NORM: begin
					rn_q <= {64'd0, an_q};
					rd_q <= {64'd0, ad_q};
				end
				DP_MUL_INIT1: begin
					mx_q   <= an_q;
					my_q   <= mul_q ? bn_q : {1'b0, bd_q};
					acc_q  <= '0;
					mcnt_q <= '0;
				end
				DP_MUL_INIT2: begin
					mx_q   <= bn_q;
					my_q   <= ad_q;
					acc_q  <= '0;
					mcnt_q <= '0;
				end
				DP_MUL_INIT3: begin
					mx_q   <= ad_q;
					my_q   <= div_q ? bn_q : {1'b0, bd_q};
					acc_q  <= '0;
					mcnt_q <= '0;
				end
				DP_MUL_STEP: begin
					acc_q  <= {acc_q[126:0], 1'b0} + (my_q[63] ? {64'd0, mx_q} : 128'd0);
					my_q   <= {my_q[62:0], 1'b0};
					mcnt_q <= mcnt_q + 6'd1;
				end
				DP_SAVE_P1: rn_q <= acc_q;
				DP_COMBINE: begin
					if (sa_q == c_s2) begin
						rn_q  <= rn_q + acc_q;
						neg_q <= sa_q;
					end else if (rn_q >= acc_q) begin
						rn_q  <= rn_q - acc_q;
						neg_q <= sa_q;
					end else begin
						rn_q  <= acc_q - rn_q;
						neg_q <= c_s2;
					end
				end
				DP_SAVE_RD: rd_q <= acc_q;
				DP_GCD_INIT: begin
					ga_q  <= rn_q;
					gb_q  <= rd_q;
					gk_q  <= '0;
					gph_q <= GCD_TWOS;
				end
				DP_GCD_STEP: begin
					case (gph_q)
						GCD_TWOS: begin
							if (!ga_q[0] && !gb_q[0]) begin
								ga_q <= ga_q >> 1;
								gb_q <= gb_q >> 1;
								gk_q <= gk_q + 7'd1;
							end else begin
								gph_q <= GCD_STRIP_A;
							end
						end
						GCD_STRIP_A: begin
							if (!ga_q[0]) begin
								ga_q <= ga_q >> 1;
							end else begin
								gph_q <= GCD_LOOP;
							end
						end
						GCD_LOOP: begin
							if (gb_q == 128'd0) begin
								gph_q <= GCD_RESTORE;
							end else if (!gb_q[0]) begin
								gb_q <= gb_q >> 1;
							end else if (ga_q > gb_q) begin
								ga_q <= gb_q;
								gb_q <= ga_q;
							end else begin
								gb_q <= gb_q - ga_q;
							end
						end
						GCD_RESTORE: begin
							if (gk_q != 7'd0) begin
								ga_q <= ga_q << 1;
								gk_q <= gk_q - 7'd1;
							end
						end
						default: gph_q <= GCD_TWOS;
					endcase
				end
				DP_DIV_INIT_N: begin
					dn_q   <= rn_q;
					rem_q  <= '0;
					dcnt_q <= '0;
				end
				DP_DIV_INIT_D: begin
					dn_q   <= rd_q;
					rem_q  <= '0;
					dcnt_q <= '0;
				end
				DP_DIV_STEP: begin
					rem_q  <= q_bit ? (rem_sh - {1'b0, ga_q}) : rem_sh;
					dn_q   <= {dn_q[126:0], q_bit};
					dcnt_q <= dcnt_q + 7'd1;
				end
				DP_SAVE_QN: rn_q <= dn_q;
				DP_SAVE_QD: rd_q <= dn_q;
				DP_EMIT: begin
					if (err_q) begin
						rsp_q.res_num <= '0;
						rsp_q.res_den <= 63'd1;
						rsp_q.status  <= ST_ZERO_DEN;
					end else if (rn_q == 128'd0) begin
						rsp_q.res_num <= '0;
						rsp_q.res_den <= 63'd1;
						rsp_q.status  <= ST_OK;
					end else if ((rd_q >= LIM) || (rn_q > (neg_q ? LIM : LIM - 128'd1))) begin
						rsp_q.res_num <= '0;
						rsp_q.res_den <= 63'd1;
						rsp_q.status  <= ST_OVERFLOW;
					end else begin
						rsp_q.status  <= ST_OK;
						rsp_q.res_num <= neg_q ? 64'(-rn_q[63:0]) : rn_q[63:0];
						rsp_q.res_den <= rd_q[62:0];
					end
				end
				default: ;
			endcase
		end
	end

	always_comb begin
		stat.err      = err_q;
		stat.norm     = norm_q;
		stat.addsub   = addsub_q;
		stat.mul_last = mcnt_q == 6'd63;
		stat.gcd_done = (gph_q == GCD_RESTORE) && (gk_q == 7'd0);
		stat.div_last = dcnt_q == 7'd127;
		stat.rn_zero  = rn_q == 128'd0;
		rsp           = rsp_q;
	end

endmodule
`default_nettype wire

### src/rau_ctrl.sv
// Controller state machine that sequences the datapath for one request.
`timescale 1ns / 1ps
`default_nettype none
module rau_ctrl import rau_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     req_valid,
	output logic          req_stall,
	output logic          rsp_valid,
	input  wire logic     rsp_stall,
	input  wire dp_stat_t stat,
	output dp_op_t        op
);
	ctrl_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE:    if (req_valid) state_d = S_CHK;
			S_CHK: begin
				if (stat.err) state_d = S_EMIT;
				else if (stat.norm) state_d = S_ZCHK;
				else state_d = S_MUL1;
			end
			S_MUL1:    if (stat.mul_last) state_d = S_SAVE1;
			S_SAVE1:   state_d = stat.addsub ? S_INIT2 : S_INIT3;
			S_INIT2:   state_d = S_MUL2;
			S_MUL2:    if (stat.mul_last) state_d = S_COMB;
			S_COMB:    state_d = S_INIT3;
			S_INIT3:   state_d = S_MUL3;
			S_MUL3:    if (stat.mul_last) state_d = S_SAVE3;
			S_SAVE3:   state_d = S_ZCHK;
			S_ZCHK:    state_d = stat.rn_zero ? S_EMIT : S_GCD;
			S_GCD:     if (stat.gcd_done) state_d = S_DINIT_N;
			S_DINIT_N: state_d = S_DIV_N;
			S_DIV_N:   if (stat.div_last) state_d = S_SAVE_QN;
			S_SAVE_QN: state_d = S_DINIT_D;
			S_DINIT_D: state_d = S_DIV_D;
			S_DIV_D:   if (stat.div_last) state_d = S_SAVE_QD;
			S_SAVE_QD: state_d = S_EMIT;
			S_EMIT:    state_d = S_OUT;
			S_OUT:     if (!rsp_stall) state_d = S_IDLE;
			default:   state_d = S_IDLE;
		endcase
	end

	always_comb begin
		op        = DP_NOP;
		req_stall = state_q != S_IDLE;
		rsp_valid = state_q == S_OUT;
		case (state_q)
			S_IDLE:    if (req_valid) op = DP_LOAD;
			S_CHK: begin
				if (stat.err) op = DP_NOP;
				else if (stat.norm) op = DP_NORM;
				else op = DP_MUL_INIT1;
			end
			S_MUL1, S_MUL2, S_MUL3: op = DP_MUL_STEP;
			S_SAVE1:   op = DP_SAVE_P1;
			S_INIT2:   op = DP_MUL_INIT2;
			S_COMB:    op = DP_COMBINE;
			S_INIT3:   op = DP_MUL_INIT3;
			S_SAVE3:   op = DP_SAVE_RD;
			S_ZCHK:    op = stat.rn_zero ? DP_NOP : DP_GCD_INIT;
			S_GCD:     op = DP_GCD_STEP;
			S_DINIT_N: op = DP_DIV_INIT_N;
			S_DIV_N, S_DIV_D: op = DP_DIV_STEP;
			S_SAVE_QN: op = DP_SAVE_QN;
			S_DINIT_D: op = DP_DIV_INIT_D;
			S_SAVE_QD: op = DP_SAVE_QD;
			S_EMIT:    op = DP_EMIT;
			default:   op = DP_NOP;
		endcase
	end

endmodule
`default_nettype wire

### src/rational_arithmetic_unit.sv
// Top level of the rational arithmetic unit: controller plus datapath.
// The request channel (req_valid, req_stall, req) carries a mode and two
// signed fractions; a request is taken at a clock edge where req_valid is
// high and req_stall is low. The response channel (rsp_valid, rsp_stall,
// rsp) returns one reduced fraction with a positive denominator and a status.
// The unit works on one request at a time and holds req_stall high from the
// cycle after a request is taken until its response has been taken.
// The work is done by a shared shift-add multiplier, a binary gcd that
// takes one shift, swap or subtract a cycle, and a restoring divider run
// twice. Normalize skips the multiplier, multiply and divide use it for
// two products and add and subtract for three. Errors found at load skip
// straight to the response, and a zero numerator skips the gcd and
// division. A new request can be taken in the cycle after the response
// has been taken. Reset clears the controller to idle and no response is
// pending afterwards. While the receiver stalls, rsp_valid and rsp stay
// put and no new request is taken.
`timescale 1ns / 1ps
`default_nettype none
module rational_arithmetic_unit import rau_pkg::*; #(
	parameter int WORD_BITS = WORD_BITS_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic req_valid,
	output logic      req_stall,
	input  wire req_t req,
	output logic      rsp_valid,
	input  wire logic rsp_stall,
	output rsp_t      rsp
);
	dp_op_t   op;
	dp_stat_t stat;

	// The controller walks through the load, multiply, gcd and divide phases.
	rau_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.stat      (stat),
		.op        (op)
	);

	// The datapath holds operands, the 128-bit intermediates and the response.
	rau_dp #(
		.WORD_BITS (WORD_BITS)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.op     (op),
		.req    (req),
		.stat   (stat),
		.rsp    (rsp)
	);

endmodule
`default_nettype wire

### src/rau_checker.sv
// Port-level checker for the rational arithmetic unit and its bind.
`timescale 1ns / 1ps
`default_nettype none
module rau_checker import rau_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic req_valid,
	input wire logic req_stall,
	input wire logic rsp_valid,
	input wire logic rsp_stall,
	input wire rsp_t rsp
);
	a_busy_on_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> req_stall) else $error("request taken while response pending");

	a_stall_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && !req_stall) |=> req_stall) else $error("no stall after request");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp)))
		else $error("stalled response changed");

	a_err_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.status != ST_OK) |-> (rsp.res_num == 64'sd0 && rsp.res_den == 63'd1))
		else $error("error response not 0/1");

	a_zero_den: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.res_num == 64'sd0) |-> (rsp.res_den == 63'd1))
		else $error("zero result not 0/1");

endmodule

bind rational_arithmetic_unit rau_checker u_rau_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_stall (req_stall),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.rsp       (rsp)
);
`default_nettype wire
